### sv/tpu_pkg.sv
// shared types, constants and decode functions for the tracker pattern unpacker
package tpu_pkg;

    localparam int MAX_TRACKS = 32;
    localparam int TRACK_LIMIT = (MAX_TRACKS > 32) ? 32 : ((MAX_TRACKS < 1) ? 1 : MAX_TRACKS);

    localparam logic [2:0] PH_HEAD  = 3'd0;
    localparam logic [2:0] PH_NOTE  = 3'd1;
    localparam logic [2:0] PH_INST  = 3'd2;
    localparam logic [2:0] PH_VOL   = 3'd3;
    localparam logic [2:0] PH_EFF   = 3'd4;
    localparam logic [2:0] PH_PARAM = 3'd5;

    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam logic [7:0] FLAG_BYTE     = 8'h80;
    localparam logic [4:0] ALL_BUT_NOTE  = 5'h1E;
    localparam logic [7:0] NOTE_MASK     = 8'h7F;
    localparam logic [7:0] NOTE_EMPTY    = 8'd255;
    localparam logic [7:0] NOTE_OFF_CODE = 8'h61;
    localparam logic [7:0] NOTE_OFF      = 8'd120;
    localparam logic [7:0] INST_NONE     = 8'd255;
    localparam logic [7:0] VOL_LOW       = 8'h10;
    localparam logic [7:0] VOL_HIGH      = 8'h50;
    localparam logic [7:0] EFF_VOLUME    = 8'h0C;
    localparam logic [7:0] NOTE_BASE     = 8'd30;
    localparam logic [7:0] OCTAVE        = 8'd12;

    typedef struct packed {
        logic [7:0] row;
        logic [4:0] column;
        logic [7:0] note;
        logic [7:0] instrument;
        logic [7:0] effect;
        logic [7:0] effect_param;
    } t_cell;

    // phase of the first flagged field at or above bit position from_bit, 0 if none
    function automatic logic [2:0] next_field(input logic [4:0] pend, input logic [2:0] from_bit);
        logic [2:0] res;
        res = PH_HEAD;
        for (int i = 4; i >= 0; i--) begin
            if (pend[i] && (3'(i) >= from_bit)) begin
                res = 3'(i + 1);
            end
        end
        return res;
    endfunction

    function automatic t_cell make_cell(
        input logic [7:0] row,
        input logic [4:0] column,
        input logic [7:0] note_in,
        input logic [7:0] inst_in,
        input logic [7:0] vol_in,
        input logic [7:0] eff_in,
        input logic [7:0] param_in
    );
        t_cell c;
        logic [7:0] n;
        logic [7:0] vdiff;
        n = note_in & NOTE_MASK;
        vdiff = vol_in - VOL_LOW;
        c.row = row;
        c.column = column;
        c.instrument = inst_in;
        c.effect = eff_in;
        c.effect_param = param_in;
        if (vol_in >= VOL_LOW && vol_in <= VOL_HIGH) begin
            c.effect = EFF_VOLUME;
            c.effect_param = {vdiff[5:0], 2'b00};
        end
        if (n == 8'd0) begin
            c.note = NOTE_EMPTY;
        end else if (n == NOTE_OFF_CODE) begin
            c.note = NOTE_OFF;
            c.instrument = INST_NONE;
        end else if (n >= NOTE_BASE) begin
            c.note = n - NOTE_BASE;
        end else if (n >= NOTE_BASE - OCTAVE) begin
            c.note = n - (NOTE_BASE - OCTAVE);
        end else if (n >= 8'(NOTE_BASE - 2 * OCTAVE)) begin
            c.note = n - 8'(NOTE_BASE - 2 * OCTAVE);
        end else begin
            c.note = n + 8'(NOTE_BASE - 2 * OCTAVE);
        end
        return c;
    endfunction

endpackage

### sv/tracker_pattern_unpacker_top.sv
// top level of the tracker pattern unpacker: byte decoder, cell counters and output queue
// Takes one packed pattern byte per clock while o_in_ready is high and gives one decoded
// cell each time an entry is complete. A request's cell, if any, is registered into the
// output register, or into the skid entry while the output register is stalled. The output
// side holds up to two cells (output register plus one skid entry), so input stalls only
// once both are full. The track_count register must be written while no request is in flight.
module tracker_pattern_unpacker_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [5:0]            i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_command,
    input  logic [7:0]            i_data_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_row,
    output logic [4:0]            o_column,
    output logic [7:0]            o_note,
    output logic [7:0]            o_instrument,
    output logic [7:0]            o_effect,
    output logic [7:0]            o_effect_param
);
    import tpu_pkg::*;

    logic [5:0] r_track_count;
    logic [2:0] r_phase,  n_phase;
    logic [4:0] r_pend,   n_pend;
    logic [7:0] r_note,   n_note;
    logic [7:0] r_inst,   n_inst;
    logic [7:0] r_vol,    n_vol;
    logic [7:0] r_eff,    n_eff;
    logic [7:0] r_row,    n_row;
    logic [4:0] r_col,    n_col;
    t_cell      r_out,    r_skid, dec_cell;
    logic       r_out_valid, r_skid_valid;

    logic       in_fire, out_take, emit;
    logic [2:0] nf;
    logic [7:0] c_note, c_inst, c_vol, c_eff, c_param;
    logic [5:0] tc, col_next;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_take = r_out_valid && i_out_ready;
    assign o_in_ready = !r_skid_valid;

    always_comb begin
        tc = r_track_count;
        if (tc == 6'd0) begin
            tc = 6'd1;
        end else if (tc > 6'(TRACK_LIMIT)) begin
            tc = 6'(TRACK_LIMIT);
        end
        col_next = {1'b0, r_col} + 6'd1;
    end

    // byte decode
    always_comb begin
        c_note = r_note;
        c_inst = r_inst;
        c_vol = r_vol;
        c_eff = r_eff;
        c_param = 8'd0;
        n_pend = r_pend;
        n_phase = r_phase;
        emit = 1'b0;
        nf = next_field(r_pend, r_phase);
        case (r_phase)
            PH_HEAD: begin
                if ((i_data_byte & FLAG_BYTE) != 8'd0) begin
                    n_pend = i_data_byte[4:0];
                    n_phase = next_field(i_data_byte[4:0], PH_HEAD);
                    emit = (n_phase == PH_HEAD);
                end else begin
                    c_note = i_data_byte;
                    n_pend = ALL_BUT_NOTE;
                    n_phase = PH_INST;
                end
            end
            PH_NOTE, PH_INST, PH_VOL, PH_EFF: begin
                if (r_phase == PH_NOTE) c_note = i_data_byte;
                if (r_phase == PH_INST) c_inst = i_data_byte;
                if (r_phase == PH_VOL)  c_vol = i_data_byte;
                if (r_phase == PH_EFF)  c_eff = i_data_byte;
                n_phase = nf;
                emit = (nf == PH_HEAD);
            end
            default: begin
                c_param = i_data_byte;
                emit = 1'b1;
            end
        endcase

        dec_cell = make_cell(r_row, r_col, c_note, c_inst, c_vol, c_eff, c_param);

        n_note = c_note;
        n_inst = c_inst;
        n_vol = c_vol;
        n_eff = c_eff;
        n_row = r_row;
        n_col = r_col;

        if (emit) begin
            if (col_next >= tc) begin
                n_col = 5'd0;
                n_row = r_row + 8'd1;
            end else begin
                n_col = col_next[4:0];
            end
        end

        if (emit || i_command == CMD_START) begin
            n_phase = PH_HEAD;
            n_pend = 5'd0;
            n_note = 8'd0;
            n_inst = INST_NONE;
            n_vol = 8'd0;
            n_eff = 8'd0;
        end

        if (i_command == CMD_START) begin
            emit = 1'b0;
            n_row = 8'd0;
            n_col = 5'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_count <= 6'd4;
            r_phase <= PH_HEAD;
            r_pend <= 5'd0;
            r_note <= 8'd0;
            r_inst <= INST_NONE;
            r_vol <= 8'd0;
            r_eff <= 8'd0;
            r_row <= 8'd0;
            r_col <= 5'd0;
        end else begin
            if (i_cfg_we) begin
                r_track_count <= i_cfg_data;
            end
            if (in_fire) begin
                r_phase <= n_phase;
                r_pend <= n_pend;
                r_note <= n_note;
                r_inst <= n_inst;
                r_vol <= n_vol;
                r_eff <= n_eff;
                r_row <= n_row;
                r_col <= n_col;
            end
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire && emit) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_fire && emit) begin
            if (r_out_valid && !out_take) begin
                r_skid <= dec_cell;
            end else begin
                r_out <= dec_cell;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_row          = r_out.row;
    assign o_column       = r_out.column;
    assign o_note         = r_out.note;
    assign o_instrument   = r_out.instrument;
    assign o_effect       = r_out.effect;
    assign o_effect_param = r_out.effect_param;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without output entry");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !out_take) |=> (r_skid_valid && $stable(r_skid)))
        else $error("skid entry lost while output stalled");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_command == CMD_START) |=>
        (r_phase == PH_HEAD && r_row == 8'd0 && r_col == 5'd0))
        else $error("start request did not clear position");

    a_head_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEAD) |-> (r_pend == 5'd0))
        else $error("pending fields left at entry head");

    a_cell_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && emit) |=> r_out_valid)
        else $error("decoded cell not shown");
`endif

endmodule
